### design/i2cbw_pkg.sv
// Shared types, constants and the microcode table of the I2C byte write master.
package i2cbw_pkg;

  localparam int unsigned NUM_BITS  = 8;
  localparam int unsigned BIT_CNT_W = $clog2(NUM_BITS);
  localparam int unsigned PC_W      = 4;
  localparam int unsigned DELAY_W   = 16;

  // Program entry points and length
  localparam logic [PC_W-1:0] STEP_START = 4'd0;
  localparam logic [PC_W-1:0] STEP_BIT   = 4'd4;
  localparam logic [PC_W-1:0] ROM_DEPTH  = 4'd13;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_WAIT
  } seq_state_t;

  typedef enum logic [1:0] {
    SDA_LOW,
    SDA_REL,
    SDA_BIT
  } sda_sel_t;

  typedef enum logic [1:0] {
    SCL_KEEP,
    SCL_LOW,
    SCL_REL
  } scl_sel_t;

  typedef struct packed {
    sda_sel_t sda_sel;
    scl_sel_t scl_sel;
    logic     dly;
    logic     shift;
    logic     loop_bits;
    logic     end_nostop;
    logic     end_prog;
  } ucode_t;

  // Strobes and line selects from the sequencer to the datapath
  typedef struct packed {
    logic     load;
    logic     emit;
    sda_sel_t sda_sel;
    scl_sel_t scl_sel;
    logic     dly;
    logic     shift;
    logic     last;
  } ctrl_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{sda_sel: SDA_REL, scl_sel: SCL_KEEP, dly: 1'b0, shift: 1'b0,
          loop_bits: 1'b0, end_nostop: 1'b0, end_prog: 1'b1};
    case (pc)
      // start condition
      4'd0: w = '{SDA_REL,  SCL_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
      4'd1: w = '{SDA_REL,  SCL_REL,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
      4'd2: w = '{SDA_LOW,  SCL_REL,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
      4'd3: w = '{SDA_LOW,  SCL_LOW,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
      // data bit, looped eight times
      4'd4: w = '{SDA_BIT,  SCL_KEEP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
      4'd5: w = '{SDA_BIT,  SCL_REL,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
      4'd6: w = '{SDA_BIT,  SCL_LOW,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
      // acknowledge clock
      4'd7: w = '{SDA_REL,  SCL_KEEP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
      4'd8: w = '{SDA_REL,  SCL_REL,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
      4'd9: w = '{SDA_REL,  SCL_LOW,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
      // stop condition
      4'd10: w = '{SDA_LOW, SCL_KEEP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
      4'd11: w = '{SDA_LOW, SCL_REL,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
      4'd12: w = '{SDA_REL, SCL_REL,  1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
      default: w = '{SDA_REL, SCL_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    endcase
    return w;
  endfunction

endpackage

### design/i2cbw_seq.sv
// Microcode sequencer: step counter, bit loop counter and bit delay timer.
module i2cbw_seq
  import i2cbw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               with_start,
  input  logic               with_stop,
  input  logic               out_free,
  input  logic [DELAY_W-1:0] delay_cycles,
  output logic               in_ready,
  output ctrl_t              ctrl
);

  seq_state_t             state;
  seq_state_t             state_next;
  logic [PC_W-1:0]        pc;
  logic [PC_W-1:0]        pc_next;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [DELAY_W-1:0]     timer;
  logic                   stop_flag;
  logic                   last_pend;
  ucode_t                 uw;
  logic                   is_last;
  logic                   bits_left;
  logic                   need_wait;
  logic                   timer_done;

  assign uw         = ucode_rom(pc);
  assign is_last    = uw.end_prog || (uw.end_nostop && !stop_flag);
  assign bits_left  = (bit_cnt != BIT_CNT_W'(NUM_BITS - 1));
  assign need_wait  = uw.dly && (delay_cycles != '0);
  assign timer_done = (timer <= DELAY_W'(1));

  always_comb begin
    if (uw.loop_bits && bits_left) begin
      pc_next = STEP_BIT;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (need_wait)    state_next = ST_WAIT;
          else if (is_last) state_next = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (timer_done) state_next = last_pend ? ST_IDLE : ST_EMIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    ctrl.load    = 1'b0;
    ctrl.emit    = 1'b0;
    ctrl.sda_sel = uw.sda_sel;
    ctrl.scl_sel = uw.scl_sel;
    ctrl.dly     = uw.dly;
    ctrl.shift   = uw.shift;
    ctrl.last    = is_last;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      ST_EMIT: begin
        ctrl.emit = out_free;
      end
      ST_WAIT: begin
        ctrl.emit = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= STEP_START;
      bit_cnt   <= '0;
      stop_flag <= 1'b0;
      last_pend <= 1'b0;
      timer     <= '0;
    end else begin
      state <= state_next;
      if (ctrl.load) begin
        pc        <= with_start ? STEP_START : STEP_BIT;
        bit_cnt   <= '0;
        stop_flag <= with_stop;
        last_pend <= 1'b0;
      end else if (ctrl.emit) begin
        pc        <= pc_next;
        last_pend <= is_last;
        timer     <= delay_cycles;
        if (uw.shift) bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      end else if (state == ST_WAIT) begin
        timer <= timer - DELAY_W'(1);
      end
    end
  end

  a_load_entry: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |=> (state == ST_EMIT) && (pc == STEP_START || pc == STEP_BIT))
    else $error("sequencer did not enter the program at an entry step");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (pc < ROM_DEPTH))
    else $error("step counter ran past the program");

  a_wait_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT) |=> $stable(pc) && $stable(bit_cnt))
    else $error("step counter moved during a bit delay");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit && is_last && !need_wait) |=> (state == ST_IDLE))
    else $error("sequencer kept running after the final action");

endmodule

### design/i2cbw_datapath.sv
// Datapath: byte shift register, line levels and the output word register.
module i2cbw_datapath
  import i2cbw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  input  logic [NUM_BITS-1:0] data_byte,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [7:0]          out_data,
  output logic                out_last
);

  logic [NUM_BITS-1:0] shreg;
  logic                sda_level;
  logic                scl_level;
  logic                sda_next;
  logic                scl_next;

  always_comb begin
    case (ctrl.sda_sel)
      SDA_LOW:  sda_next = 1'b0;
      SDA_REL:  sda_next = 1'b1;
      SDA_BIT:  sda_next = shreg[NUM_BITS-1];
      default:  sda_next = 1'b1;
    endcase
    case (ctrl.scl_sel)
      SCL_KEEP: scl_next = scl_level;
      SCL_LOW:  scl_next = 1'b0;
      SCL_REL:  scl_next = 1'b1;
      default:  scl_next = scl_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sda_level <= 1'b1;
      scl_level <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.emit) begin
        sda_level <= sda_next;
        scl_level <= scl_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      shreg <= data_byte;
    end else if (ctrl.emit && ctrl.shift) begin
      shreg <= {shreg[NUM_BITS-2:0], 1'b0};
    end
    if (ctrl.emit) begin
      out_data <= {5'b0, ctrl.dly, scl_next, sda_next};
      out_last <= ctrl.last;
    end
  end

endmodule

### design/i2c_byte_write_master.sv
// Top level of the write-only open-drain I2C byte master.
//
// Usage:
//  - s_* stream: one word per byte. s_tdata[7:0] is the byte, sent MSB first;
//    s_tuser[0] asks for a start condition before it, s_tuser[1] for a stop
//    condition after the acknowledge clock.
//  - m_* stream: one word per line action. m_tdata[0] is SDA released,
//    m_tdata[1] SCL released, m_tdata[2] says a bit delay follows; m_tlast
//    marks the final action of a byte.
//  - cfg_* channel: writes delay_cycles, the bit delay in clock cycles
//    (reset 32); always ready. Write it only while idle.
// Sequence: a byte expands into 27 to 34 actions. Once the byte is taken,
// the sequencer emits its actions one by one as the output register frees; an
// action that carries a bit delay is followed by a wait for delay_cycles,
// timed by the sequencer's delay timer. s_tready is high only between bytes.
// Stalls: when m_tready is low the finished action holds in the output
// register and the sequencer stops at its current step; nothing is dropped.
// Reset: both lines read as released, the sequencer returns to idle and
// delay_cycles goes back to 32.
module i2c_byte_write_master
  import i2cbw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic [1:0]  s_tuser,    // [0] with_start, [1] with_stop
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [0] sda_released, [1] scl_released,
                                  // [2] delay_after, [7:3] zero
  output logic        m_tlast,    // last_action
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // delay_cycles
);

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd32;

  logic [DELAY_W-1:0] delay_cycles;
  logic               out_free;
  ctrl_t              ctrl;

  // The configuration register takes every write at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_cycles <= DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delay_cycles <= cfg_data;
    end
  end

  // Output register may take a new word when empty or being drained.
  assign out_free = !m_tvalid || m_tready;

  i2cbw_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .with_start   (s_tuser[0]),
    .with_stop    (s_tuser[1]),
    .out_free     (out_free),
    .delay_cycles (delay_cycles),
    .in_ready     (s_tready),
    .ctrl         (ctrl)
  );

  i2cbw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .data_byte (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

### tb/sv/testbench.sv
// Testbench for the I2C byte write master: byte stream in, checked line actions out.
`timescale 1ns / 1ps

module testbench;
  import i2cbw_pkg::*;

  // One line action as the master stream reports it
  typedef struct packed {
    logic sda;
    logic scl;
    logic dly;
    logic last;
  } line_action_t;

  // One directed stimulus row; a typed first action is checked as written
  typedef struct packed {
    logic [7:0]   data;
    logic         start;
    logic         stop;
    logic         typed;
    line_action_t first;
  } byte_row_t;

  localparam int unsigned NUM_ROWS    = 14;
  localparam int unsigned CYCLE_LIMIT = 10_000_000;

  // Directed part: extremes of the byte, every start/stop combination, bytes
  // sent without a start (mid-frame or straight after reset) and repeated stops
  localparam byte_row_t DIRECTED [NUM_ROWS] = '{
    // no start right after reset: SCL still released, first bit driven low
    '{8'h00, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b0}},
    // start after an acknowledge clock: SCL low, release SDA first
    '{8'hFF, 1'b1, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0}},
    // no start after a stop: both lines released, first bit high
    '{8'hFF, 1'b0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0}},
    '{8'h80, 1'b1, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b1, 1'b0, '0},
    '{8'hFE, 1'b1, 1'b1, 1'b0, '0},
    '{8'h55, 1'b1, 1'b0, 1'b0, '0},
    '{8'hAA, 1'b0, 1'b1, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, '0},
    '{8'hC3, 1'b1, 1'b0, 1'b0, '0},
    '{8'h3C, 1'b0, 1'b1, 1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;     // [7:0] data_byte
  logic [1:0]         s_tuser = '0;     // [0] with_start, [1] with_stop
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;          // [0] sda, [1] scl, [2] delay_after, [7:3] zero
  logic               m_tlast;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [DELAY_W-1:0] cfg_data = '0;    // delay_cycles

  // Predicted bus state, configuration copy and expected actions
  logic               line_sda;
  logic               line_scl;
  logic [DELAY_W-1:0] bit_delay;
  line_action_t       bus_actions [$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_mode  = 0;
  line_action_t head;

  i2c_byte_write_master dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Append one action and track the line levels it leaves behind
  function automatic void add_action(input logic sda, input logic scl, input logic dly);
    line_action_t a;
    a.sda = sda;
    a.scl = scl;
    a.dly = dly;
    a.last = 1'b0;
    line_sda = sda;
    line_scl = scl;
    bus_actions.push_back(a);
  endfunction

  // Expand one accepted byte into its line actions
  function automatic void expand_byte(input logic [7:0] data, input logic start,
                                      input logic stop, input logic typed,
                                      input line_action_t first);
    int unsigned  idx;
    line_action_t tail;
    idx = bus_actions.size();
    if (start) begin
      add_action(1'b1, line_scl, 1'b0);
      add_action(1'b1, 1'b1, 1'b1);
      add_action(1'b0, 1'b1, 1'b1);
      add_action(1'b0, 1'b0, 1'b0);
    end
    // data bits, MSB first; SCL keeps its level on the SDA change
    for (int i = 7; i >= 0; i--) begin
      add_action(data[i], line_scl, 1'b1);
      add_action(data[i], 1'b1, 1'b1);
      add_action(data[i], 1'b0, 1'b0);
    end
    // acknowledge clock with SDA released; the slave's answer is not sampled
    add_action(1'b1, line_scl, 1'b1);
    add_action(1'b1, 1'b1, 1'b1);
    add_action(1'b1, 1'b0, 1'b0);
    if (stop) begin
      add_action(1'b0, line_scl, 1'b1);
      add_action(1'b0, 1'b1, 1'b1);
      add_action(1'b1, 1'b1, 1'b1);
    end
    tail = bus_actions.pop_back();
    tail.last = 1'b1;
    bus_actions.push_back(tail);
    if (typed) bus_actions[idx] = first;
  endfunction

  // Cycles to let pass after the last action so that its bit delay runs out
  function automatic int unsigned settle_cycles();
    return (bit_delay == 0) ? 70_000 : int'(bit_delay) + 16;
  endfunction

  // Send one byte word: open a new burst after a random gap when the old one is used up
  task automatic send_word(input logic [7:0] data, input logic start, input logic stop,
                           input logic typed, input line_action_t first);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
    end
    burst_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= {stop, start};
    do @(posedge clk); while (!s_tready);
    expand_byte(data, start, stop, typed, first);
  endtask

  // Write delay_cycles once the block has drained and its last delay has run out
  task automatic write_delay(input logic [DELAY_W-1:0] value);
    s_tvalid <= 1'b0;
    while (bus_actions.size() != 0) @(posedge clk);
    repeat (settle_cycles()) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bit_delay = value;
  endtask

  // Random phase: mostly well-formed frames, the rest loose bytes with random flags
  task automatic random_phase(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(1, 4);
        for (int unsigned k = 0; k < len; k++) begin
          send_word(8'($urandom_range(0, 255)), k == 0, k == len - 1, 1'b0, '0);
        end
        sent += len;
      end else begin
        send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Compare one field of the received action and report a mismatch
  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Check every accepted action word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (bus_actions.size() == 0) begin
        $error("line action: expected none, actual tdata %0h tlast %0d", m_tdata, m_tlast);
        fail_count++;
      end else begin
        head = bus_actions.pop_front();
        check_field("sda_released", 32'(head.sda), 32'(m_tdata[0]));
        check_field("scl_released", 32'(head.scl), 32'(m_tdata[1]));
        check_field("delay_after", 32'(head.dly), 32'(m_tdata[2]));
        check_field("tdata padding", 32'd0, 32'(m_tdata[7:3]));
        check_field("last_action", 32'(head.last), 32'(m_tlast));
      end
    end
  end

  // Receiver: switch between free running, light and heavy stalls, each mode held for a random span
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(64, 512);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog: end the run as failed once the cycle count reaches CYCLE_LIMIT
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    line_sda  = 1'b1;
    line_scl  = 1'b1;
    bit_delay = 16'd32;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at the reset delay
    for (int unsigned r = 0; r < NUM_ROWS; r++) begin
      send_word(DIRECTED[r].data, DIRECTED[r].start, DIRECTED[r].stop,
                DIRECTED[r].typed, DIRECTED[r].first);
    end

    // Random phases, the shortest delay among them
    write_delay(16'd1);
    random_phase(40);
    write_delay(16'($urandom_range(2, 5)));
    random_phase(40);
    write_delay(16'($urandom_range(1, 8)));
    random_phase(40);
    write_delay(16'($urandom_range(2, 12)));
    random_phase(40);

    // Longest delay, then zero delay, one plain byte each
    write_delay(16'hFFFF);
    send_word(8'hA5, 1'b0, 1'b0, 1'b0, '0);
    write_delay(16'd0);
    send_word(8'h5A, 1'b0, 1'b0, 1'b0, '0);

    // Drain the expectations, then watch for stray actions
    s_tvalid <= 1'b0;
    while (bus_actions.size() != 0) @(posedge clk);
    repeat (settle_cycles()) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/i2cbw_pkg.sv
design/i2cbw_seq.sv
design/i2cbw_datapath.sv
design/i2c_byte_write_master.sv
tb/sv/testbench.sv
